// ===== rtl/core/scc_pkg.sv =====
// Shared types and constants for the strongly connected components block.
// No dependencies; the interfaces, the core and the testbench import this package.
package scc_pkg;

   localparam int MAX_NODES = 1024;
   localparam int MAX_EDGES = 4096;
   localparam int NODE_W    = 10;   // node number
   localparam int CNT_W     = 11;   // node count, component count
   localparam int EDGE_W    = 13;   // edge count, list position
   localparam int EIDX_W    = 12;   // edge store / list address
   localparam int SADDR_W   = 11;   // start table address (MAX_NODES + 1 entries)

   typedef logic [NODE_W-1:0] node_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [EDGE_W-1:0] edge_count_type;
   typedef logic [1:0]        op_type;

   localparam op_type OP_LOAD   = 2'd0;
   localparam op_type OP_FINISH = 2'd1;
   localparam op_type OP_QUERY  = 2'd2;

   // One depth-first frame: node, next list position, end of its list
   typedef struct packed {
      node_type       node;
      edge_count_type pos;
      edge_count_type last;
   } frame_type;

endpackage

// ===== rtl/core/scc_if.sv =====
// Channel interfaces: request, response and register write.
// Depends on scc_pkg.
interface scc_req_if import scc_pkg::*; ();
   logic     valid;
   logic     ready;
   op_type   op;
   node_type from_node;
   node_type to_node;
   modport source(output valid, op, from_node, to_node, input ready);
   modport sink(input valid, op, from_node, to_node, output ready);
endinterface

interface scc_rsp_if import scc_pkg::*; ();
   logic      valid;
   logic      ready;
   node_type  component_id;
   count_type component_total;
   logic      bad_node;
   logic      edges_dropped;
   modport source(output valid, component_id, component_total, bad_node, edges_dropped,
                  input ready);
   modport sink(input valid, component_id, component_total, bad_node, edges_dropped,
                output ready);
endinterface

interface scc_csr_if import scc_pkg::*; ();
   logic      valid;
   logic      ready;
   count_type node_count;
   modport source(output valid, node_count, input ready);
   modport sink(input valid, node_count, output ready);
endinterface

// ===== rtl/core/scc_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
module scc_ram #(
   parameter int DEPTH  = 1024,
   parameter int WIDTH  = 8,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== rtl/core/strongly_connected_components.sv =====
// Strongly connected components (two-pass depth-first decomposition).
// Load: 1 beat per cycle while idle with no response held. Query: read and response are
// registered; no beat is taken until the response leaves. Finish: all passes run serially
// through one-read, one-write memories (edge store, start tables, lists, stack, marks).
// Synchronous active-high reset: empty edge store, no decomposition, node_count 1.
module strongly_connected_components import scc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   scc_req_if.sink      req_bus,
   scc_rsp_if.source    rsp_bus,
   scc_csr_if.sink      csr_bus
);

   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_ZERO     = 5'd1;
   localparam logic [4:0] ST_CNT_RD   = 5'd2;
   localparam logic [4:0] ST_CNT_ST   = 5'd3;
   localparam logic [4:0] ST_CNT_WR   = 5'd4;
   localparam logic [4:0] ST_PFX_RD   = 5'd5;
   localparam logic [4:0] ST_PFX_WR   = 5'd6;
   localparam logic [4:0] ST_PLC_RD   = 5'd7;
   localparam logic [4:0] ST_PLC_ST   = 5'd8;
   localparam logic [4:0] ST_PLC_WR   = 5'd9;
   localparam logic [4:0] ST_ROOT_RD  = 5'd10;
   localparam logic [4:0] ST_ROOT_FO  = 5'd11;
   localparam logic [4:0] ST_ROOT_CHK = 5'd12;
   localparam logic [4:0] ST_S0       = 5'd13;
   localparam logic [4:0] ST_S1       = 5'd14;
   localparam logic [4:0] ST_STEP     = 5'd15;
   localparam logic [4:0] ST_POP      = 5'd16;
   localparam logic [4:0] ST_W1       = 5'd17;
   localparam logic [4:0] ST_W2       = 5'd18;
   localparam logic [4:0] ST_CLR      = 5'd19;
   localparam logic [4:0] ST_DONE     = 5'd20;

   localparam count_type      N_MAX = count_type'(MAX_NODES);
   localparam edge_count_type E_MAX = edge_count_type'(MAX_EDGES);

   // control and payload registers
   logic [4:0]     state_ff, state_in;
   edge_count_type idx_ff, idx_in;
   count_type      node_count_ff, node_count_in;
   edge_count_type edge_total_ff, edge_total_in;
   logic           drop_ff, drop_in;
   logic           decomposed_ff, decomposed_in;
   count_type      comps_ff, comps_in;
   count_type      dec_nodes_ff, dec_nodes_in;
   count_type      nfin_ff, nfin_in;
   logic           pass_ff, pass_in;
   count_type      done_ff, done_in;
   count_type      sp_ff, sp_in;
   frame_type      top_ff, top_in;
   node_type       w_ff, w_in;
   edge_count_type fsum_ff, fsum_in, rsum_ff, rsum_in;
   count_type      comp_cnt_ff, comp_cnt_in;
   node_type       e_from_ff, e_from_in, e_to_ff, e_to_in;
   logic           q_pend_ff, q_pend_in, q_bad_ff, q_bad_in;
   logic           rsp_valid_ff, rsp_valid_in;
   node_type       rsp_id_ff, rsp_id_in;
   count_type      rsp_total_ff, rsp_total_in;
   logic           rsp_bad_ff, rsp_bad_in, rsp_drop_ff, rsp_drop_in;

   // memory ports
   logic                      edge_we, fst_we, rst_we, fl_we, rl_we, vis_we;
   logic                      fo_we, stk_we, comp_we;
   logic [EIDX_W-1:0]         edge_wa, edge_ra, fl_wa, rl_wa, fl_ra;
   logic [2*NODE_W-1:0]       edge_wd, edge_rd;
   logic [SADDR_W-1:0]        fst_wa, rst_wa, fst_ra, rst_ra;
   edge_count_type            fst_wd, rst_wd, fst_rd, rst_rd;
   node_type                  fl_wd, rl_wd, fl_rd, rl_rd;
   node_type                  vis_wa, vis_ra, fo_wa, fo_ra, stk_wa, stk_ra;
   node_type                  comp_wa, comp_ra;
   logic                      vis_wd, vis_rd;
   node_type                  fo_wd, fo_rd, comp_wd, comp_rd;
   frame_type                 stk_wd, stk_rd;

   // derived values
   count_type      n_eff;
   edge_count_type idx_dec, start_rd;
   node_type       list_rd, ed_from, ed_to;
   logic           ed_ok;
   logic           req_fire;

   assign n_eff    = (node_count_ff > N_MAX) ? N_MAX : node_count_ff;
   assign idx_dec  = idx_ff - 1'b1;
   assign start_rd = pass_ff ? rst_rd : fst_rd;
   assign list_rd  = pass_ff ? rl_rd : fl_rd;
   assign ed_from  = edge_rd[2*NODE_W-1:NODE_W];
   assign ed_to    = edge_rd[NODE_W-1:0];
   assign ed_ok    = ({1'b0, ed_from} < nfin_ff) && ({1'b0, ed_to} < nfin_ff);

   assign req_bus.ready = (state_ff == ST_IDLE) && !q_pend_ff && !rsp_valid_ff;
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign csr_bus.ready = 1'b1;

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.component_id    = rsp_id_ff;
   assign rsp_bus.component_total = rsp_total_ff;
   assign rsp_bus.bad_node        = rsp_bad_ff;
   assign rsp_bus.edges_dropped   = rsp_drop_ff;

   // memories
   scc_ram #(.DEPTH(MAX_EDGES), .WIDTH(2*NODE_W)) u_edge (
      .clock(clock), .we(edge_we), .waddr(edge_wa), .wdata(edge_wd),
      .raddr(edge_ra), .rdata(edge_rd));
   scc_ram #(.DEPTH(MAX_NODES+1), .WIDTH(EDGE_W)) u_fst (
      .clock(clock), .we(fst_we), .waddr(fst_wa), .wdata(fst_wd),
      .raddr(fst_ra), .rdata(fst_rd));
   scc_ram #(.DEPTH(MAX_NODES+1), .WIDTH(EDGE_W)) u_rst (
      .clock(clock), .we(rst_we), .waddr(rst_wa), .wdata(rst_wd),
      .raddr(rst_ra), .rdata(rst_rd));
   scc_ram #(.DEPTH(MAX_EDGES), .WIDTH(NODE_W)) u_flist (
      .clock(clock), .we(fl_we), .waddr(fl_wa), .wdata(fl_wd),
      .raddr(fl_ra), .rdata(fl_rd));
   scc_ram #(.DEPTH(MAX_EDGES), .WIDTH(NODE_W)) u_rlist (
      .clock(clock), .we(rl_we), .waddr(rl_wa), .wdata(rl_wd),
      .raddr(fl_ra), .rdata(rl_rd));
   scc_ram #(.DEPTH(MAX_NODES), .WIDTH(1)) u_vis (
      .clock(clock), .we(vis_we), .waddr(vis_wa), .wdata(vis_wd),
      .raddr(vis_ra), .rdata(vis_rd));
   scc_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_fo (
      .clock(clock), .we(fo_we), .waddr(fo_wa), .wdata(fo_wd),
      .raddr(fo_ra), .rdata(fo_rd));
   scc_ram #(.DEPTH(MAX_NODES), .WIDTH($bits(frame_type))) u_stk (
      .clock(clock), .we(stk_we), .waddr(stk_wa), .wdata(stk_wd),
      .raddr(stk_ra), .rdata(stk_rd));
   scc_ram #(.DEPTH(MAX_NODES), .WIDTH(NODE_W)) u_comp (
      .clock(clock), .we(comp_we), .waddr(comp_wa), .wdata(comp_wd),
      .raddr(comp_ra), .rdata(comp_rd));

   // next-state and memory control
   always_comb begin
      edge_count_type lt, fpos, rpos;
      count_type      nn;
      state_in      = state_ff;
      idx_in        = idx_ff;
      node_count_in = node_count_ff;
      edge_total_in = edge_total_ff;
      drop_in       = drop_ff;
      decomposed_in = decomposed_ff;
      comps_in      = comps_ff;
      dec_nodes_in  = dec_nodes_ff;
      nfin_in       = nfin_ff;
      pass_in       = pass_ff;
      done_in       = done_ff;
      sp_in         = sp_ff;
      top_in        = top_ff;
      w_in          = w_ff;
      fsum_in       = fsum_ff;
      rsum_in       = rsum_ff;
      comp_cnt_in   = comp_cnt_ff;
      e_from_in     = e_from_ff;
      e_to_in       = e_to_ff;
      q_pend_in     = 1'b0;
      q_bad_in      = q_bad_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_id_in     = rsp_id_ff;
      rsp_total_in  = rsp_total_ff;
      rsp_bad_in    = rsp_bad_ff;
      rsp_drop_in   = rsp_drop_ff;

      edge_we = 1'b0; edge_wa = '0; edge_wd = '0; edge_ra = idx_ff[EIDX_W-1:0];
      fst_we = 1'b0; fst_wa = '0; fst_wd = '0; fst_ra = idx_ff[SADDR_W-1:0];
      rst_we = 1'b0; rst_wa = '0; rst_wd = '0; rst_ra = idx_ff[SADDR_W-1:0];
      fl_we = 1'b0; fl_wa = '0; fl_wd = '0; fl_ra = top_ff.pos[EIDX_W-1:0];
      rl_we = 1'b0; rl_wa = '0; rl_wd = '0;
      vis_we = 1'b0; vis_wa = '0; vis_wd = 1'b0; vis_ra = idx_ff[NODE_W-1:0];
      fo_we = 1'b0; fo_wa = done_ff[NODE_W-1:0]; fo_wd = top_ff.node;
      fo_ra = idx_dec[NODE_W-1:0];
      stk_we = 1'b0; stk_wa = idx_ff[NODE_W-1:0]; stk_wd = top_ff;
      stk_ra = idx_ff[NODE_W-1:0];
      comp_we = 1'b0; comp_wa = top_ff.node; comp_wd = comp_cnt_ff[NODE_W-1:0];
      comp_ra = req_bus.from_node;
      lt = '0; fpos = '0; rpos = '0;
      nn = {1'b0, top_ff.node} + 1'b1;

      if (csr_bus.valid) begin
         node_count_in = csr_bus.node_count;
      end

      // query result registered from the component read data
      if (q_pend_ff) begin
         rsp_valid_in = 1'b1;
         rsp_id_in    = q_bad_ff ? '0 : comp_rd;
         rsp_total_in = comps_ff;
         rsp_bad_in   = q_bad_ff;
         rsp_drop_in  = drop_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_bus.op)
                  OP_LOAD: begin
                     lt = decomposed_ff ? '0 : edge_total_ff;
                     if (decomposed_ff) begin
                        drop_in       = 1'b0;
                        decomposed_in = 1'b0;
                     end
                     if ({1'b0, req_bus.from_node} >= n_eff ||
                         {1'b0, req_bus.to_node} >= n_eff || lt >= E_MAX) begin
                        drop_in       = 1'b1;
                        edge_total_in = lt;
                     end else begin
                        edge_we       = 1'b1;
                        edge_wa       = lt[EIDX_W-1:0];
                        edge_wd       = {req_bus.from_node, req_bus.to_node};
                        edge_total_in = lt + 1'b1;
                     end
                  end
                  OP_FINISH: begin
                     nfin_in     = n_eff;
                     comp_cnt_in = '0;
                     idx_in      = '0;
                     state_in    = (n_eff == '0) ? ST_DONE : ST_ZERO;
                  end
                  OP_QUERY: begin
                     q_pend_in = 1'b1;
                     q_bad_in  = !decomposed_ff || ({1'b0, req_bus.from_node} >= n_eff) ||
                                 ({1'b0, req_bus.from_node} >= dec_nodes_ff);
                  end
                  default: begin
                  end
               endcase
            end
         end

         // clear start tables (0..n) and visit marks
         ST_ZERO: begin
            fst_we = 1'b1; fst_wa = idx_ff[SADDR_W-1:0];
            rst_we = 1'b1; rst_wa = idx_ff[SADDR_W-1:0];
            vis_we = 1'b1; vis_wa = idx_ff[NODE_W-1:0];
            if (idx_ff[SADDR_W-1:0] == nfin_ff) begin
               idx_in   = '0;
               state_in = ST_CNT_RD;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end

         // count out-degree and in-degree
         ST_CNT_RD: begin
            if (idx_ff == edge_total_ff) begin
               idx_in   = '0;
               fsum_in  = '0;
               rsum_in  = '0;
               state_in = ST_PFX_RD;
            end else begin
               state_in = ST_CNT_ST;
            end
         end
         ST_CNT_ST: begin
            e_from_in = ed_from;
            e_to_in   = ed_to;
            fst_ra    = {1'b0, ed_from};
            rst_ra    = {1'b0, ed_to};
            if (ed_ok) begin
               state_in = ST_CNT_WR;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_CNT_RD;
            end
         end
         ST_CNT_WR: begin
            fst_we = 1'b1; fst_wa = {1'b0, e_from_ff}; fst_wd = fst_rd + 1'b1;
            rst_we = 1'b1; rst_wa = {1'b0, e_to_ff};   rst_wd = rst_rd + 1'b1;
            idx_in   = idx_ff + 1'b1;
            state_in = ST_CNT_RD;
         end

         // running sum: each start entry becomes the end of its list
         ST_PFX_RD: begin
            state_in = ST_PFX_WR;
         end
         ST_PFX_WR: begin
            fsum_in = fsum_ff + fst_rd;
            rsum_in = rsum_ff + rst_rd;
            fst_we = 1'b1; fst_wa = idx_ff[SADDR_W-1:0]; fst_wd = fsum_ff + fst_rd;
            rst_we = 1'b1; rst_wa = idx_ff[SADDR_W-1:0]; rst_wd = rsum_ff + rst_rd;
            if (idx_ff[SADDR_W-1:0] == nfin_ff) begin
               idx_in   = edge_total_ff;
               state_in = ST_PLC_RD;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_PFX_RD;
            end
         end

         // place edges, last to first, so each list keeps load order
         ST_PLC_RD: begin
            edge_ra = idx_dec[EIDX_W-1:0];
            if (idx_ff == '0) begin
               pass_in  = 1'b0;
               done_in  = '0;
               state_in = ST_ROOT_RD;
            end else begin
               state_in = ST_PLC_ST;
            end
         end
         ST_PLC_ST: begin
            e_from_in = ed_from;
            e_to_in   = ed_to;
            fst_ra    = {1'b0, ed_from};
            rst_ra    = {1'b0, ed_to};
            if (ed_ok) begin
               state_in = ST_PLC_WR;
            end else begin
               idx_in   = idx_dec;
               state_in = ST_PLC_RD;
            end
         end
         ST_PLC_WR: begin
            fpos = fst_rd - 1'b1;
            rpos = rst_rd - 1'b1;
            fst_we = 1'b1; fst_wa = {1'b0, e_from_ff}; fst_wd = fpos;
            rst_we = 1'b1; rst_wa = {1'b0, e_to_ff};   rst_wd = rpos;
            fl_we = 1'b1; fl_wa = fpos[EIDX_W-1:0]; fl_wd = e_to_ff;
            rl_we = 1'b1; rl_wa = rpos[EIDX_W-1:0]; rl_wd = e_from_ff;
            idx_in   = idx_dec;
            state_in = ST_PLC_RD;
         end

         // root selection: node order first, reversed finish order second
         ST_ROOT_RD: begin
            if (!pass_ff) begin
               if (idx_ff[SADDR_W-1:0] == nfin_ff) begin
                  idx_in   = '0;
                  state_in = ST_CLR;
               end else begin
                  top_in.node = idx_ff[NODE_W-1:0];
                  state_in    = ST_ROOT_CHK;
               end
            end else begin
               if (idx_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_ROOT_FO;
               end
            end
         end
         ST_ROOT_FO: begin
            vis_ra      = fo_rd;
            top_in.node = fo_rd;
            state_in    = ST_ROOT_CHK;
         end
         ST_ROOT_CHK: begin
            fst_ra = {1'b0, top_ff.node};
            rst_ra = {1'b0, top_ff.node};
            if (vis_rd) begin
               idx_in   = pass_ff ? idx_dec : idx_ff + 1'b1;
               state_in = ST_ROOT_RD;
            end else begin
               vis_we = 1'b1; vis_wa = top_ff.node; vis_wd = 1'b1;
               comp_we  = pass_ff;
               sp_in    = count_type'(1);
               state_in = ST_S0;
            end
         end

         // fetch list bounds of the top frame
         ST_S0: begin
            top_in.pos = start_rd;
            fst_ra     = nn;
            rst_ra     = nn;
            state_in   = ST_S1;
         end
         ST_S1: begin
            top_in.last = start_rd;
            state_in    = ST_STEP;
         end

         // advance along the list or retire the frame
         ST_STEP: begin
            stk_ra = sp_ff[NODE_W-1:0] - 2'd2;
            if (top_ff.pos < top_ff.last) begin
               top_in.pos = top_ff.pos + 1'b1;
               state_in   = ST_W1;
            end else begin
               if (!pass_ff) begin
                  fo_we   = 1'b1;
                  done_in = done_ff + 1'b1;
               end
               if (sp_ff == count_type'(1)) begin
                  sp_in = '0;
                  if (pass_ff) begin
                     comp_cnt_in = comp_cnt_ff + 1'b1;
                  end
                  idx_in   = pass_ff ? idx_dec : idx_ff + 1'b1;
                  state_in = ST_ROOT_RD;
               end else begin
                  sp_in    = sp_ff - 1'b1;
                  state_in = ST_POP;
               end
            end
         end
         ST_POP: begin
            top_in   = stk_rd;
            state_in = ST_STEP;
         end
         ST_W1: begin
            w_in     = list_rd;
            vis_ra   = list_rd;
            state_in = ST_W2;
         end
         ST_W2: begin
            fst_ra = {1'b0, w_ff};
            rst_ra = {1'b0, w_ff};
            if (vis_rd) begin
               state_in = ST_STEP;
            end else begin
               vis_we = 1'b1; vis_wa = w_ff; vis_wd = 1'b1;
               comp_we = pass_ff; comp_wa = w_ff;
               stk_we  = 1'b1; stk_wa = sp_ff[NODE_W-1:0] - 1'b1;
               top_in.node = w_ff;
               sp_in       = sp_ff + 1'b1;
               state_in    = ST_S0;
            end
         end

         // clear visit marks before the reverse pass
         ST_CLR: begin
            if (idx_ff[SADDR_W-1:0] == nfin_ff) begin
               pass_in  = 1'b1;
               idx_in   = {2'b00, done_ff};
               state_in = ST_ROOT_RD;
            end else begin
               vis_we   = 1'b1; vis_wa = idx_ff[NODE_W-1:0];
               idx_in   = idx_ff + 1'b1;
            end
         end

         ST_DONE: begin
            comps_in      = comp_cnt_ff;
            decomposed_in = 1'b1;
            dec_nodes_in  = nfin_ff;
            rsp_valid_in  = 1'b1;
            rsp_id_in     = '0;
            rsp_total_in  = comp_cnt_ff;
            rsp_bad_in    = 1'b0;
            rsp_drop_in   = drop_ff;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         node_count_ff <= count_type'(1);
         edge_total_ff <= '0;
         drop_ff       <= 1'b0;
         decomposed_ff <= 1'b0;
         comps_ff      <= '0;
         dec_nodes_ff  <= '0;
         q_pend_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_count_ff <= node_count_in;
         edge_total_ff <= edge_total_in;
         drop_ff       <= drop_in;
         decomposed_ff <= decomposed_in;
         comps_ff      <= comps_in;
         dec_nodes_ff  <= dec_nodes_in;
         q_pend_ff     <= q_pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff       <= idx_in;
      nfin_ff      <= nfin_in;
      pass_ff      <= pass_in;
      done_ff      <= done_in;
      sp_ff        <= sp_in;
      top_ff       <= top_in;
      w_ff         <= w_in;
      fsum_ff      <= fsum_in;
      rsum_ff      <= rsum_in;
      comp_cnt_ff  <= comp_cnt_in;
      e_from_ff    <= e_from_in;
      e_to_ff      <= e_to_in;
      q_bad_ff     <= q_bad_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_total_ff <= rsp_total_in;
      rsp_bad_ff   <= rsp_bad_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

endmodule

// ===== verif/tb_strongly_connected_components.sv =====
// Self-checking testbench for strongly_connected_components: a directed table, then
// random graphs checked against an in-bench Kosaraju predictor.
// Depends on scc_pkg and the channel interfaces in scc_if.sv.
module tb_strongly_connected_components;
   import scc_pkg::*;

   typedef struct {
      node_type  id;
      count_type total;
      logic      bad;
      logic      dropped;
   } answer_type;

   typedef struct {
      bit         is_cfg;     // row writes node_count instead of sending a beat
      count_type  cfg_value;
      op_type     op;
      node_type   a;
      node_type   b;
      bit         typed;      // expected answer given in the row
      answer_type answer;
   } row_type;

   localparam op_type OP_NONE  = 2'd3;
   localparam int     SETTLE   = 40;      // idle cycles before a register write
   localparam int     N_ITEMS  = 1750;

   logic clock = 1'b0;
   logic reset = 1'b1;

   scc_req_if req_bus();
   scc_rsp_if rsp_bus();
   scc_csr_if csr_bus();

   strongly_connected_components u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus.sink),
      .rsp_bus (rsp_bus.source),
      .csr_bus (csr_bus.sink)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------- graph predictor ----------------
   node_type   edge_src [MAX_EDGES];
   node_type   edge_dst [MAX_EDGES];
   int         stored_edges;
   bit         drop_seen;
   bit         graph_solved;
   int         solved_nodes;
   int         scc_total;
   count_type  nodes_cfg;
   int         fwd_start [MAX_NODES+1];
   int         rev_start [MAX_NODES+1];
   int         fwd_list [MAX_EDGES];
   int         rev_list [MAX_EDGES];
   bit         seen [MAX_NODES];
   int         finished [MAX_NODES];
   int         stk_node [MAX_NODES];
   int         stk_pos [MAX_NODES];
   int         scc_of [MAX_NODES];

   answer_type pending_answers[$];

   function automatic int live_nodes();
      return (nodes_cfg < MAX_NODES) ? int'(nodes_cfg) : MAX_NODES;
   endfunction

   // Counting sort of the usable edges into adjacency lists, load order kept
   function automatic void build_adjacency(int n, bit reversed);
      int cnt [MAX_NODES+1];
      int sum, valid, s, d;
      sum = 0;
      valid = 0;
      for (int i = 0; i <= MAX_NODES; i++) cnt[i] = 0;
      for (int i = 0; i < stored_edges; i++) begin
         if (edge_src[i] < n && edge_dst[i] < n) begin
            s = reversed ? edge_dst[i] : edge_src[i];
            cnt[s]++;
            valid++;
         end
      end
      for (int i = 0; i < n; i++) begin
         sum += cnt[i];
         cnt[i] = sum;
      end
      cnt[n] = valid;
      for (int e = stored_edges - 1; e >= 0; e--) begin
         if (edge_src[e] < n && edge_dst[e] < n) begin
            s = reversed ? edge_dst[e] : edge_src[e];
            d = reversed ? edge_src[e] : edge_dst[e];
            cnt[s]--;
            if (reversed) rev_list[cnt[s]] = d;
            else fwd_list[cnt[s]] = d;
         end
      end
      for (int i = 0; i <= MAX_NODES; i++) begin
         if (reversed) rev_start[i] = cnt[i];
         else fwd_start[i] = cnt[i];
      end
   endfunction

   // Iterative depth-first walk; labeling pass on reverse edges, else finish order
   function automatic void walk_from(int root, bit labeling, ref int done);
      int sp, v, w, lim;
      sp = 1;
      seen[root] = 1'b1;
      if (labeling) scc_of[root] = scc_total;
      stk_node[0] = root;
      stk_pos[0] = labeling ? rev_start[root] : fwd_start[root];
      while (sp > 0) begin
         v = stk_node[sp-1];
         lim = labeling ? rev_start[v+1] : fwd_start[v+1];
         if (stk_pos[sp-1] < lim) begin
            w = labeling ? rev_list[stk_pos[sp-1]] : fwd_list[stk_pos[sp-1]];
            stk_pos[sp-1]++;
            if (!seen[w] && sp < MAX_NODES) begin
               seen[w] = 1'b1;
               if (labeling) scc_of[w] = scc_total;
               stk_node[sp] = w;
               stk_pos[sp] = labeling ? rev_start[w] : fwd_start[w];
               sp++;
            end
         end else begin
            if (!labeling && done < MAX_NODES) begin
               finished[done] = v;
               done++;
            end
            sp--;
         end
      end
   endfunction

   function automatic void decompose_graph();
      int n, done, r;
      n = live_nodes();
      done = 0;
      scc_total = 0;
      solved_nodes = n;
      graph_solved = 1'b1;
      if (n == 0) return;
      build_adjacency(n, 1'b0);
      build_adjacency(n, 1'b1);
      for (int i = 0; i < MAX_NODES; i++) seen[i] = 1'b0;
      for (int i = 0; i < n; i++)
         if (!seen[i]) walk_from(i, 1'b0, done);
      for (int i = 0; i < MAX_NODES; i++) seen[i] = 1'b0;
      for (int i = done; i > 0; i--) begin
         r = finished[i-1];
         if (!seen[r]) begin
            walk_from(r, 1'b1, done);
            scc_total++;
         end
      end
   endfunction

   // Apply one accepted beat; returns 1 and the answer when one is due
   function automatic bit predict_beat(op_type op, node_type a, node_type b,
                                       output answer_type ans);
      int  n;
      bit  bad;
      n = live_nodes();
      ans = '{default: '0};
      case (op)
         OP_LOAD: begin
            if (graph_solved) begin
               stored_edges = 0;
               drop_seen = 1'b0;
               graph_solved = 1'b0;
            end
            if (a >= n || b >= n || stored_edges >= MAX_EDGES) drop_seen = 1'b1;
            else begin
               edge_src[stored_edges] = a;
               edge_dst[stored_edges] = b;
               stored_edges++;
            end
            return 1'b0;
         end
         OP_FINISH: begin
            decompose_graph();
            ans.total = count_type'(scc_total);
            ans.dropped = drop_seen;
            return 1'b1;
         end
         OP_QUERY: begin
            bad = !graph_solved || a >= n || a >= solved_nodes;
            ans.id = bad ? '0 : node_type'(scc_of[a]);
            ans.total = count_type'(scc_total);
            ans.bad = bad;
            ans.dropped = drop_seen;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic bit same_answer(answer_type x, answer_type y);
      return x.id == y.id && x.total == y.total && x.bad == y.bad &&
             x.dropped == y.dropped;
   endfunction

   // ---------------- stimulus side ----------------
   int send_idle_pct = 0;
   int stall_pct = 0;
   int hold_cycles = 0;
   int beats_sent = 0;
   int answers_checked = 0;
   int mismatches = 0;
   int cfg_writes = 0;
   int finishes_sent = 0;

   initial begin
      req_bus.valid = 1'b0;
      req_bus.op = OP_LOAD;
      req_bus.from_node = '0;
      req_bus.to_node = '0;
      csr_bus.valid = 1'b0;
      csr_bus.node_count = '0;
      rsp_bus.ready = 1'b0;
   end

   // Present one beat from the falling edge until accepted; typed answer optional
   task automatic send_beat(op_type op, node_type a, node_type b,
                            bit typed, answer_type typed_ans);
      answer_type ans;
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.op = op;
      req_bus.from_node = a;
      req_bus.to_node = b;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (predict_beat(op, a, b, ans)) begin
         if (typed && !same_answer(ans, typed_ans))
            $display("note: predictor disagrees with table row, op %0d node %0d", op, a);
         pending_answers.insert(pending_answers.size(), typed ? typed_ans : ans);
      end
      if (op == OP_FINISH) finishes_sent++;
      beats_sent++;
      @(negedge clock);
   endtask

   // Register writes only once every answer is back and the block has settled
   task automatic write_node_count(count_type value);
      req_bus.valid = 1'b0;
      while (pending_answers.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.node_count = value;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      nodes_cfg = value;
      cfg_writes++;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   function automatic node_type pick_node(int n);
      if (n > 0 && $urandom_range(9) != 0) return node_type'($urandom_range(n - 1));
      return node_type'($urandom);
   endfunction

   // ---------------- result side ----------------
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_bus.ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_bus.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response beat: id %0d total %0d bad %0b dropped %0b",
                        rsp_bus.component_id, rsp_bus.component_total,
                        rsp_bus.bad_node, rsp_bus.edges_dropped);
         end else begin
            want = pending_answers.pop_front();
            answers_checked++;
            if (rsp_bus.component_id !== want.id || rsp_bus.component_total !== want.total ||
                rsp_bus.bad_node !== want.bad || rsp_bus.edges_dropped !== want.dropped) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"response %0d: expected id %0d total %0d bad %0b dropped %0b,",
                            " got id %0d total %0d bad %0b dropped %0b"},
                           answers_checked, want.id, want.total, want.bad, want.dropped,
                           rsp_bus.component_id, rsp_bus.component_total,
                           rsp_bus.bad_node, rsp_bus.edges_dropped);
            end
         end
      end
   end

   // ---------------- directed table ----------------
   function automatic row_type mk(op_type op, int a, int b);
      row_type r;
      r = '{default: '0};
      r.op = op;
      r.a = node_type'(a);
      r.b = node_type'(b);
      return r;
   endfunction

   function automatic row_type mk_typed(op_type op, int a, int id, int total, bit bad, bit dr);
      row_type r;
      r = mk(op, a, 0);
      r.typed = 1'b1;
      r.answer = '{id: node_type'(id), total: count_type'(total), bad: bad, dropped: dr};
      return r;
   endfunction

   function automatic row_type mk_cfg(int value);
      row_type r;
      r = '{default: '0};
      r.is_cfg = 1'b1;
      r.cfg_value = count_type'(value);
      return r;
   endfunction

   row_type directed[$];

   function automatic void add_row(row_type r);
      directed.insert(directed.size(), r);
   endfunction

   task automatic run_graph_phase(int mode);
      int n, loads, queries;
      answer_type none;
      none = '{default: '0};
      case (mode % 4)
         0: begin send_idle_pct = 0;  stall_pct = 0;  end
         1: begin send_idle_pct = 86; stall_pct = 0;  end
         2: begin send_idle_pct = 0;  stall_pct = 86; end
         default: begin send_idle_pct = 37; stall_pct = 37; end
      endcase
      // mostly small graphs; the occasional full-size or degenerate count
      case ($urandom_range(19))
         0:       n = 1024;
         1:       n = 2047;
         2:       n = 0;
         default: n = $urandom_range(1, 12);
      endcase
      write_node_count(count_type'(n));
      if (n > MAX_NODES) n = MAX_NODES;
      loads = (n >= 64) ? $urandom_range(0, 40) : $urandom_range(0, 3 * n + 2);
      for (int i = 0; i < loads; i++) begin
         if ($urandom_range(19) == 0) send_beat(OP_NONE, node_type'($urandom),
                                                 node_type'($urandom), 1'b0, none);
         else if ($urandom_range(29) == 0) send_beat(OP_QUERY, pick_node(n), '0, 1'b0, none);
         else send_beat(OP_LOAD, pick_node(n), pick_node(n), 1'b0, none);
      end
      send_beat(OP_FINISH, node_type'($urandom), node_type'($urandom), 1'b0, none);
      if ($urandom_range(7) == 0) send_beat(OP_FINISH, '0, '0, 1'b0, none);
      queries = $urandom_range(2, 10);
      for (int i = 0; i < queries; i++)
         send_beat(OP_QUERY, pick_node(n), node_type'($urandom), 1'b0, none);
   endtask

   initial begin
      answer_type none;
      int phase;
      none = '{default: '0};
      nodes_cfg = 1;
      stored_edges = 0;
      drop_seen = 0;
      graph_solved = 0;
      solved_nodes = 0;
      scc_total = 0;
      for (int i = 0; i < MAX_NODES; i++) scc_of[i] = 0;

      add_row(mk_typed(OP_QUERY, 0, 0, 0, 1, 0));      // nothing solved yet
      add_row(mk_typed(OP_FINISH, 0, 0, 1, 0, 0));     // lone node
      add_row(mk_typed(OP_QUERY, 0, 0, 1, 0, 0));
      add_row(mk_typed(OP_QUERY, 1023, 0, 1, 1, 0));   // node out of range
      add_row(mk(OP_NONE, 1023, 1023));                // unused op
      add_row(mk(OP_LOAD, 0, 0));                      // new graph, self loop
      add_row(mk(OP_LOAD, 1023, 0));                   // dropped edge
      add_row(mk_typed(OP_QUERY, 0, 0, 1, 1, 1));      // stale after new loads
      add_row(mk_typed(OP_FINISH, 0, 0, 1, 0, 1));
      add_row(mk_typed(OP_FINISH, 0, 0, 1, 0, 1));     // repeated finish
      add_row(mk_cfg(1024));
      add_row(mk(OP_LOAD, 0, 1023));
      add_row(mk(OP_LOAD, 1023, 0));
      add_row(mk(OP_LOAD, 5, 6));
      add_row(mk(OP_LOAD, 1023, 1023));
      add_row(mk(OP_FINISH, 0, 0));
      add_row(mk(OP_QUERY, 1023, 0));
      add_row(mk(OP_QUERY, 0, 0));
      add_row(mk(OP_QUERY, 6, 0));
      add_row(mk_cfg(4));                              // shrunken node count
      add_row(mk(OP_FINISH, 0, 0));
      add_row(mk(OP_QUERY, 3, 0));
      add_row(mk(OP_QUERY, 5, 0));
      add_row(mk_cfg(0));
      add_row(mk_typed(OP_FINISH, 0, 0, 0, 0, 0));     // empty node set
      add_row(mk(OP_QUERY, 0, 0));

      repeat (12) @(negedge clock);
      reset = 1'b0;

      foreach (directed[i]) begin
         if (directed[i].is_cfg) write_node_count(directed[i].cfg_value);
         else send_beat(directed[i].op, directed[i].a, directed[i].b,
                        directed[i].typed, directed[i].answer);
      end

      // random graphs
      phase = 0;
      while (beats_sent < N_ITEMS) begin
         run_graph_phase(phase);
         phase++;
         // long receiver hold-off while queries keep coming
         if (phase == 20) begin
            send_idle_pct = 0;
            stall_pct = 0;
            hold_cycles = 400;
            for (int i = 0; i < 40; i++)
               send_beat(OP_QUERY, pick_node(live_nodes()), '0, 1'b0, none);
         end
      end
      req_bus.valid = 1'b0;

      while (pending_answers.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);

      $display("covered %0d beats, %0d finishes, %0d node-count writes, %0d responses checked",
               beats_sent, finishes_sent, cfg_writes, answers_checked);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // watchdog
   initial begin
      #8000000;
      $display("timeout with %0d responses outstanding", pending_answers.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
